/* design/pooled_stats_merge_unit_defines.svh */
// Assertion macros shared by the pooled statistics merge RTL.
`ifndef POOLED_STATS_MERGE_UNIT_DEFINES_SVH
`define POOLED_STATS_MERGE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psm: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psm: next-cycle check failed");

`endif

/* design/psm_pkg.sv */
// Types and constants for the pooled statistics merge unit.
`timescale 1ns / 1ps

package psm_pkg;

    localparam int DATA_W    = 32;
    localparam int ROWS_W    = 33;
    localparam int MD_STAGES = 32;   // quotient bits of the mean divide
    localparam int VD_STAGES = 64;   // quotient bits of the variance divide
    localparam int SQ_STAGES = 32;   // root bits of the square root

    typedef enum logic [1:0] {
        MODE_CAT  = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_DICT = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MODE_SEL = 2'd0,
        CFG_ROWS_A   = 2'd1,
        CFG_ROWS_B   = 2'd2
    } t_cfg_idx;

    // Fields that ride along the whole pipe
    typedef struct packed {
        logic [31:0] mean;
        logic [31:0] stdev;
        logic [31:0] count;
        logic        mrg;
    } t_side;

    typedef struct packed {
        logic        v;
        t_side       side;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] sa;
        logic [31:0] sb;
    } t_in;

    typedef struct packed {
        logic        v;
        t_side       side;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] pa;
        logic [63:0] pb;
        logic [63:0] sqa;
        logic [63:0] sqb;
    } t_p1;

    typedef struct packed {
        logic        v;
        t_side       side;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] sqa;
        logic [63:0] sqb;
        logic [32:0] rem;
        logic [31:0] lq;
    } t_md;

    typedef struct packed {
        logic        v;
        t_side       side;
        logic [31:0] ad1;
        logic [31:0] ad2;
        logic [63:0] sqa;
        logic [63:0] sqb;
    } t_v1;

    typedef struct packed {
        logic             v;
        t_side            side;
        logic [3:0][63:0] x;
    } t_v2;

    typedef struct packed {
        logic             v;
        t_side            side;
        logic [3:0][63:0] plo;
        logic [3:0][63:0] phi;
    } t_v3;

    typedef struct packed {
        logic             v;
        t_side            side;
        logic [3:0][95:0] prod;
    } t_v4;

    typedef struct packed {
        logic             v;
        t_side            side;
        logic [1:0][96:0] ps;
    } t_v5;

    typedef struct packed {
        logic        v;
        t_side       side;
        logic        sat;
        logic [32:0] rem;
        logic [63:0] lq;
    } t_vd;

    typedef struct packed {
        logic        v;
        t_side       side;
        logic        sat;
        logic [63:0] x;
        logic [33:0] rem;
        logic [31:0] root;
    } t_sq;

    typedef struct packed {
        logic        v;
        logic [31:0] mean;
        logic [31:0] stdev;
        logic [31:0] count;
        logic [32:0] rows;
    } t_out;

endpackage

/* design/pooled_stats_merge_unit.sv */
// Top level of the pooled statistics merge unit: a deep pipeline.
//
//  channel  | handshake             | beat contents
//  ---------+-----------------------+--------------------------------------------
//  input    | i_valid / o_ready     | mean, stdev, count of sides A and B
//  output   | o_valid / i_ready     | mean_out, stdev_out, count_out, rows_total
//  config   | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// One beat enters per cycle while the output is not stalled; there are 139 register
// stages. The depth is set by the bit-per-stage mean divide (32), variance divide
// (64) and square root (32).
// Reset (synchronous, active low) clears all valid bits and the configuration registers.
// A stall at the output freezes every stage at once; nothing is lost.
`timescale 1ns / 1ps
`include "pooled_stats_merge_unit_defines.svh"

module pooled_stats_merge_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_mean_a,
    input  logic [31:0] i_stdev_a,
    input  logic [31:0] i_count_a,
    input  logic [31:0] i_mean_b,
    input  logic [31:0] i_stdev_b,
    input  logic [31:0] i_count_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_mean_out,
    output logic [31:0] o_stdev_out,
    output logic [31:0] o_count_out,
    output logic [32:0] o_rows_total
);

    localparam int MDS = psm_pkg::MD_STAGES;
    localparam int VDS = psm_pkg::VD_STAGES;
    localparam int SQS = psm_pkg::SQ_STAGES;

    // configuration registers
    psm_pkg::t_mode r_mode;
    logic [31:0]    r_rows_a;
    logic [31:0]    r_rows_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= psm_pkg::MODE_CAT;
            r_rows_a <= '0;
            r_rows_b <= '0;
        end else if (i_cfg_we) begin
            case (psm_pkg::t_cfg_idx'(i_cfg_idx))
                psm_pkg::CFG_MODE_SEL: r_mode   <= psm_pkg::t_mode'(i_cfg_data[1:0]);
                psm_pkg::CFG_ROWS_A:   r_rows_a <= i_cfg_data;
                psm_pkg::CFG_ROWS_B:   r_rows_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // derived row values, which the user must keep stable while beats are in flight; the block does not enforce this
    logic [32:0]      w_nt;
    logic [32:0]      w_dv;
    logic [32:0]      w_half;
    logic [3:0][31:0] w_mul;
    logic             w_en;

    assign w_nt     = {1'b0, r_rows_a} + {1'b0, r_rows_b};
    assign w_dv     = w_nt - 33'd1;
    assign w_half   = w_nt >> 1;
    assign w_mul[0] = r_rows_a - 32'd1;
    assign w_mul[1] = r_rows_a;
    assign w_mul[2] = r_rows_b - 32'd1;
    assign w_mul[3] = r_rows_b;

    psm_pkg::t_in  r_in,  n_in;
    psm_pkg::t_p1  r_p1,  n_p1;
    psm_pkg::t_md  r_md [0:MDS];
    psm_pkg::t_md  n_md0;
    psm_pkg::t_v1  r_v1,  n_v1;
    psm_pkg::t_v2  r_v2,  n_v2;
    psm_pkg::t_v3  r_v3,  n_v3;
    psm_pkg::t_v4  r_v4,  n_v4;
    psm_pkg::t_v5  r_v5,  n_v5;
    psm_pkg::t_vd  r_vd [0:VDS];
    psm_pkg::t_vd  n_vd0;
    psm_pkg::t_sq  r_sq [0:SQS];
    psm_pkg::t_sq  n_sq0;
    psm_pkg::t_out r_o,   n_o;

    // whole pipe advances unless the output beat is stuck
    assign w_en    = !r_o.v || i_ready;
    assign o_ready = w_en;

    // input stage: pass-through fields and count merge
    logic        w_use_cnt;
    logic        w_use_mean;
    logic [32:0] w_csum;

    always_comb begin
        w_use_cnt  = (r_mode == psm_pkg::MODE_CAT) || (r_mode == psm_pkg::MODE_DICT);
        w_use_mean = (r_mode == psm_pkg::MODE_NUM) || (r_mode == psm_pkg::MODE_DICT);
        w_csum     = {1'b0, i_count_a} + {1'b0, i_count_b};
        n_in.v     = i_valid;
        n_in.ma    = i_mean_a;
        n_in.mb    = i_mean_b;
        n_in.sa    = i_stdev_a;
        n_in.sb    = i_stdev_b;
        n_in.side.mrg = (r_rows_a != '0) && (r_rows_b != '0) && w_use_mean;
        if (r_rows_a == '0) begin
            n_in.side.mean  = i_mean_b;
            n_in.side.stdev = i_stdev_b;
            n_in.side.count = i_count_b;
        end else begin
            n_in.side.mean  = i_mean_a;
            n_in.side.stdev = i_stdev_a;
            n_in.side.count = i_count_a;
            if (r_rows_b != '0 && w_use_cnt) begin
                n_in.side.count = w_csum[32] ? '1 : w_csum[31:0];
            end
        end
    end

    // products for the weighted sum and the squared standard deviations
    always_comb begin
        n_p1.v    = r_in.v;
        n_p1.side = r_in.side;
        n_p1.ma   = r_in.ma;
        n_p1.mb   = r_in.mb;
        n_p1.pa   = 64'(r_in.ma ^ 32'h8000_0000) * 64'(r_rows_a);
        n_p1.pb   = 64'(r_in.mb ^ 32'h8000_0000) * 64'(r_rows_b);
        n_p1.sqa  = 64'(r_in.sa) * 64'(r_in.sa);
        n_p1.sqb  = 64'(r_in.sb) * 64'(r_in.sb);
    end

    // rounded numerator; its upper half is below the divisor
    logic [64:0] w_num;

    always_comb begin
        w_num       = {1'b0, r_p1.pa} + {1'b0, r_p1.pb} + {32'd0, w_half};
        n_md0.v     = r_p1.v;
        n_md0.side  = r_p1.side;
        n_md0.ma    = r_p1.ma;
        n_md0.mb    = r_p1.mb;
        n_md0.sqa   = r_p1.sqa;
        n_md0.sqb   = r_p1.sqb;
        n_md0.rem   = w_num[64:32];
        n_md0.lq    = w_num[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.v    <= 1'b0;
            r_p1.v    <= 1'b0;
            r_md[0].v <= 1'b0;
        end else if (w_en) begin
            r_in     <= n_in;
            r_p1     <= n_p1;
            r_md[0]  <= n_md0;
        end
    end

    // mean divide: one quotient bit per stage
    for (genvar k = 1; k <= MDS; k++) begin : g_md
        psm_pkg::t_md n_md;
        logic [33:0]  w_t;
        logic [33:0]  w_d;
        logic         w_ge;

        always_comb begin
            n_md     = r_md[k-1];
            w_t      = {r_md[k-1].rem, r_md[k-1].lq[31]};
            w_d      = w_t - {1'b0, w_nt};
            w_ge     = w_t >= {1'b0, w_nt};
            n_md.rem = w_ge ? w_d[32:0] : w_t[32:0];
            n_md.lq  = {r_md[k-1].lq[30:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_md[k].v <= 1'b0;
            end else if (w_en) begin
                r_md[k] <= n_md;
            end
        end
    end

    // deviations from the pooled mean
    logic [31:0] w_mq;
    logic [32:0] w_d1;
    logic [32:0] w_d2;
    logic [32:0] w_nd1;
    logic [32:0] w_nd2;

    always_comb begin
        w_mq      = r_md[MDS].lq ^ 32'h8000_0000;
        w_d1      = {r_md[MDS].ma[31], r_md[MDS].ma} - {w_mq[31], w_mq};
        w_d2      = {r_md[MDS].mb[31], r_md[MDS].mb} - {w_mq[31], w_mq};
        w_nd1     = -w_d1;
        w_nd2     = -w_d2;
        n_v1.v    = r_md[MDS].v;
        n_v1.side = r_md[MDS].side;
        if (r_md[MDS].side.mrg) begin
            n_v1.side.mean = w_mq;
        end
        n_v1.ad1  = w_d1[32] ? w_nd1[31:0] : w_d1[31:0];
        n_v1.ad2  = w_d2[32] ? w_nd2[31:0] : w_d2[31:0];
        n_v1.sqa  = r_md[MDS].sqa;
        n_v1.sqb  = r_md[MDS].sqb;
    end

    // squared deviations
    always_comb begin
        n_v2.v    = r_v1.v;
        n_v2.side = r_v1.side;
        n_v2.x[0] = r_v1.sqa;
        n_v2.x[1] = 64'(r_v1.ad1) * 64'(r_v1.ad1);
        n_v2.x[2] = r_v1.sqb;
        n_v2.x[3] = 64'(r_v1.ad2) * 64'(r_v1.ad2);
    end

    // 64x32 products split into two 32x32 halves
    always_comb begin
        n_v3.v    = r_v2.v;
        n_v3.side = r_v2.side;
        for (int j = 0; j < 4; j++) begin
            n_v3.plo[j] = 64'(r_v2.x[j][31:0]) * 64'(w_mul[j]);
            n_v3.phi[j] = 64'(r_v2.x[j][63:32]) * 64'(w_mul[j]);
        end
    end

    // recombine halves
    always_comb begin
        n_v4.v    = r_v3.v;
        n_v4.side = r_v3.side;
        for (int j = 0; j < 4; j++) begin
            n_v4.prod[j] = {r_v3.phi[j], 32'd0} + {32'd0, r_v3.plo[j]};
        end
    end

    // pair sums
    always_comb begin
        n_v5.v     = r_v4.v;
        n_v5.side  = r_v4.side;
        n_v5.ps[0] = {1'b0, r_v4.prod[0]} + {1'b0, r_v4.prod[1]};
        n_v5.ps[1] = {1'b0, r_v4.prod[2]} + {1'b0, r_v4.prod[3]};
    end

    // final sum and overflow check against the divisor
    logic [97:0] w_acc;

    always_comb begin
        w_acc       = {1'b0, r_v5.ps[0]} + {1'b0, r_v5.ps[1]};
        n_vd0.v     = r_v5.v;
        n_vd0.side  = r_v5.side;
        n_vd0.sat   = w_acc[97:64] >= {1'b0, w_dv};
        n_vd0.rem   = n_vd0.sat ? '0 : w_acc[96:64];
        n_vd0.lq    = w_acc[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1.v    <= 1'b0;
            r_v2.v    <= 1'b0;
            r_v3.v    <= 1'b0;
            r_v4.v    <= 1'b0;
            r_v5.v    <= 1'b0;
            r_vd[0].v <= 1'b0;
        end else if (w_en) begin
            r_v1    <= n_v1;
            r_v2    <= n_v2;
            r_v3    <= n_v3;
            r_v4    <= n_v4;
            r_v5    <= n_v5;
            r_vd[0] <= n_vd0;
        end
    end

    // variance divide: one quotient bit per stage
    for (genvar k = 1; k <= VDS; k++) begin : g_vd
        psm_pkg::t_vd n_vd;
        logic [33:0]  w_t;
        logic [33:0]  w_d;
        logic         w_ge;

        always_comb begin
            n_vd     = r_vd[k-1];
            w_t      = {r_vd[k-1].rem, r_vd[k-1].lq[63]};
            w_d      = w_t - {1'b0, w_dv};
            w_ge     = w_t >= {1'b0, w_dv};
            n_vd.rem = w_ge ? w_d[32:0] : w_t[32:0];
            n_vd.lq  = {r_vd[k-1].lq[62:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k].v <= 1'b0;
            end else if (w_en) begin
                r_vd[k] <= n_vd;
            end
        end
    end

    // square root setup
    always_comb begin
        n_sq0.v    = r_vd[VDS].v;
        n_sq0.side = r_vd[VDS].side;
        n_sq0.sat  = r_vd[VDS].sat;
        n_sq0.x    = r_vd[VDS].lq;
        n_sq0.rem  = '0;
        n_sq0.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq[0].v <= 1'b0;
        end else if (w_en) begin
            r_sq[0] <= n_sq0;
        end
    end

    // square root: one root bit per stage
    for (genvar k = 1; k <= SQS; k++) begin : g_sq
        psm_pkg::t_sq n_sq;
        logic [35:0]  w_t;
        logic [35:0]  w_trial;
        logic [35:0]  w_d;
        logic         w_ge;

        always_comb begin
            n_sq      = r_sq[k-1];
            w_t       = {r_sq[k-1].rem, r_sq[k-1].x[63:62]};
            w_trial   = {2'b00, r_sq[k-1].root, 2'b01};
            w_d       = w_t - w_trial;
            w_ge      = w_t >= w_trial;
            n_sq.rem  = w_ge ? w_d[33:0] : w_t[33:0];
            n_sq.root = {r_sq[k-1].root[30:0], w_ge};
            n_sq.x    = {r_sq[k-1].x[61:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[k].v <= 1'b0;
            end else if (w_en) begin
                r_sq[k] <= n_sq;
            end
        end
    end

    // output register
    always_comb begin
        n_o.v     = r_sq[SQS].v;
        n_o.mean  = r_sq[SQS].side.mean;
        n_o.count = r_sq[SQS].side.count;
        n_o.rows  = w_nt;
        if (!r_sq[SQS].side.mrg) begin
            n_o.stdev = r_sq[SQS].side.stdev;
        end else if (r_sq[SQS].sat) begin
            n_o.stdev = '1;
        end else begin
            n_o.stdev = r_sq[SQS].root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o.v <= 1'b0;
        end else if (w_en) begin
            r_o <= n_o;
        end
    end

    assign o_valid      = r_o.v;
    assign o_mean_out   = r_o.mean;
    assign o_stdev_out  = r_o.stdev;
    assign o_count_out  = r_o.count;
    assign o_rows_total = r_o.rows;

    // checks
    `PSM_ASSERT_SAME(a_mean_rem, i_clk, i_rst_n, r_md[MDS].v && r_md[MDS].side.mrg, r_md[MDS].rem < w_nt)
    `PSM_ASSERT_SAME(a_var_rem, i_clk, i_rst_n, r_vd[VDS].v && r_vd[VDS].side.mrg && !r_vd[VDS].sat, r_vd[VDS].rem < w_dv)
    `PSM_ASSERT_NEXT(a_stall_freeze, i_clk, i_rst_n, !w_en, $stable(r_sq[SQS].root) && $stable(r_vd[VDS].lq))

endmodule

/* tb/pooled_stats_merge_checker.sv */
// Checker for the pooled statistics merge unit: shadows config, predicts and compares beats.
`timescale 1ns / 1ps

module pooled_stats_merge_checker
    import psm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [31:0] i_mean_a,
    input  logic [31:0] i_stdev_a,
    input  logic [31:0] i_count_a,
    input  logic [31:0] i_mean_b,
    input  logic [31:0] i_stdev_b,
    input  logic [31:0] i_count_b,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_mean_out,
    input  logic [31:0] i_stdev_out,
    input  logic [31:0] i_count_out,
    input  logic [32:0] i_rows_total,
    output int          o_pending,
    output int          o_fail_count
);

    typedef struct {
        logic [31:0] mean;
        logic [31:0] stdev;
        logic [31:0] count;
        logic [32:0] rows;
    } t_pooled;

    t_mode       mode_q;
    logic [31:0] rows_a_q;
    logic [31:0] rows_b_q;
    t_pooled     pooled_q[$];

    // floor square root of a 64-bit value, one root bit at a time
    function automatic logic [31:0] floor_sqrt(logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (32'd1 << i);
            if (64'(trial) * 64'(trial) <= v) root = trial;
        end
        return root;
    endfunction

    function automatic t_pooled pool_stats(logic [31:0] ma, logic [31:0] sa, logic [31:0] ca,
                                           logic [31:0] mb, logic [31:0] sb, logic [31:0] cb);
        t_pooled      r;
        logic [32:0]  nt;
        logic [127:0] wsum;
        logic [127:0] quo;
        logic [127:0] acc;
        logic [127:0] var_q;
        logic [31:0]  mq;
        logic [33:0]  d1;
        logic [33:0]  d2;
        logic [32:0]  m1;
        logic [32:0]  m2;
        logic [32:0]  csum;
        nt = {1'b0, rows_a_q} + {1'b0, rows_b_q};
        r.rows = nt;
        if (rows_a_q == 0) begin
            r.mean = mb; r.stdev = sb; r.count = cb;
            return r;
        end
        r.mean = ma; r.stdev = sa; r.count = ca;
        if (rows_b_q == 0) return r;
        if (mode_q == MODE_NUM || mode_q == MODE_DICT) begin
            // offset-binary weighted sum, rounded half up
            wsum = 128'(ma ^ 32'h8000_0000) * 128'(rows_a_q)
                 + 128'(mb ^ 32'h8000_0000) * 128'(rows_b_q);
            quo = (wsum + 128'(nt >> 1)) / 128'(nt);
            mq = quo[31:0] ^ 32'h8000_0000;
            d1 = $signed({{2{ma[31]}}, ma}) - $signed({{2{mq[31]}}, mq});
            d2 = $signed({{2{mb[31]}}, mb}) - $signed({{2{mq[31]}}, mq});
            m1 = d1[33] ? 33'(-d1) : 33'(d1);
            m2 = d2[33] ? 33'(-d2) : 33'(d2);
            acc = 128'(sa) * 128'(sa) * 128'(rows_a_q - 32'd1)
                + 128'(m1) * 128'(m1) * 128'(rows_a_q)
                + 128'(sb) * 128'(sb) * 128'(rows_b_q - 32'd1)
                + 128'(m2) * 128'(m2) * 128'(rows_b_q);
            var_q = acc / 128'(nt - 33'd1);
            r.mean = mq;
            r.stdev = (var_q[127:64] != 0) ? 32'hFFFF_FFFF : floor_sqrt(var_q[63:0]);
        end
        if (mode_q == MODE_CAT || mode_q == MODE_DICT) begin
            csum = {1'b0, ca} + {1'b0, cb};
            r.count = csum[32] ? 32'hFFFF_FFFF : csum[31:0];
        end
        return r;
    endfunction

    assign o_pending = pooled_q.size();

    always @(posedge i_clk) begin
        t_pooled exp_r;
        if (!i_rst_n) begin
            mode_q   <= MODE_CAT;
            rows_a_q <= '0;
            rows_b_q <= '0;
            pooled_q.delete();
            o_fail_count <= 0;
        end else begin
            // config shadow
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MODE_SEL: mode_q   <= t_mode'(i_cfg_data[1:0]);
                    CFG_ROWS_A:   rows_a_q <= i_cfg_data;
                    CFG_ROWS_B:   rows_b_q <= i_cfg_data;
                    default: ;
                endcase
            end
            // input beat -> expectation
            if (i_valid && i_ready_in)
                pooled_q.push_back(pool_stats(i_mean_a, i_stdev_a, i_count_a,
                                              i_mean_b, i_stdev_b, i_count_b));
            // output beat -> compare
            if (i_out_valid && i_out_ready) begin
                if (pooled_q.size() == 0) begin
                    $display("%0t: unexpected output beat mean=%h stdev=%h count=%h rows=%h",
                             $time, i_mean_out, i_stdev_out, i_count_out, i_rows_total);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = pooled_q.pop_front();
                    if (exp_r.mean !== i_mean_out || exp_r.stdev !== i_stdev_out ||
                        exp_r.count !== i_count_out || exp_r.rows !== i_rows_total) begin
                        $display("%0t: mismatch exp mean=%h stdev=%h count=%h rows=%h",
                                 $time, exp_r.mean, exp_r.stdev, exp_r.count, exp_r.rows);
                        $display("%0t:          act mean=%h stdev=%h count=%h rows=%h",
                                 $time, i_mean_out, i_stdev_out, i_count_out, i_rows_total);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_pooled_stats_merge_unit.sv */
// Testbench top for the pooled statistics merge unit: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_pooled_stats_merge_unit;
    import psm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_mean_a, i_stdev_a, i_count_a;
    logic [31:0] i_mean_b, i_stdev_b, i_count_b;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_mean_out, o_stdev_out, o_count_out;
    logic [32:0] o_rows_total;

    int pending;
    int fail_count;
    bit quiet_mode;   // no idling on either side
    bit hold_req;     // ask receiver for one long hold-off
    bit hold_done;    // receiver has served the hold-off
    int hold_left;
    int stall_cycles;

    always #5 i_clk = ~i_clk;

    pooled_stats_merge_unit u_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_ready,
        .i_mean_a, .i_stdev_a, .i_count_a, .i_mean_b, .i_stdev_b, .i_count_b,
        .o_valid, .i_ready, .o_mean_out, .o_stdev_out, .o_count_out, .o_rows_total
    );

    pooled_stats_merge_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready),
        .i_mean_a, .i_stdev_a, .i_count_a, .i_mean_b, .i_stdev_b, .i_count_b,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_mean_out(o_mean_out), .i_stdev_out(o_stdev_out),
        .i_count_out(o_count_out), .i_rows_total(o_rows_total),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    // receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 6);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // field value biased toward corners
    function automatic logic [31:0] pick_field();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(300));
            5:       return 32'($urandom_range(32'h0040_0000)) - 32'h0020_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_rows();
        case ($urandom_range(5))
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return 32'($urandom_range(1, 50));
        endcase
    endfunction

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_config(t_mode mode, logic [31:0] ra, logic [31:0] rb);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_write(CFG_MODE_SEL, 32'(mode));
        cfg_write(CFG_ROWS_A, ra);
        cfg_write(CFG_ROWS_B, rb);
    endtask

    // one input beat, with an optional one-cycle gap ahead of it
    task automatic send_beat(logic [31:0] ma, logic [31:0] sa, logic [31:0] ca,
                             logic [31:0] mb, logic [31:0] sb, logic [31:0] cb);
        if (!quiet_mode && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mean_a  <= ma; i_stdev_a <= sa; i_count_a <= ca;
        i_mean_b  <= mb; i_stdev_b <= sb; i_count_b <= cb;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_random(int n);
        for (int k = 0; k < n; k++)
            send_beat(pick_field(), pick_field(), pick_field(),
                      pick_field(), pick_field(), pick_field());
        i_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_MODE_SEL;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_mean_a   <= '0; i_stdev_a <= '0; i_count_a <= '0;
        i_mean_b   <= '0; i_stdev_b <= '0; i_count_b <= '0;
        quiet_mode = 1'b0;
        hold_req   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners, dictionary mode
        set_config(MODE_DICT, 32'd3, 32'd5);
        send_beat(32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0000_0000, 32'h0000_0000, 32'h0);
        send_beat(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(32'h8000_0000, 32'h0, 32'h1, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFE);
        send_beat(32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
        send_beat(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_beat(32'h0001_0000, 32'h0001_0000, 32'd10, 32'hFFFF_0000, 32'h0002_0000, 32'd20);
        send_beat(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
        send_beat(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_beat(32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0000_0002, 32'h0000_0001, 32'h0);
        send_random(80);

        // side A empty, then side B empty
        set_config(MODE_DICT, 32'd0, 32'd7);
        send_random(80);
        set_config(MODE_NUM, 32'd9, 32'd0);
        send_random(80);

        // counts only, with one long receiver hold-off
        set_config(MODE_CAT, 32'd4, 32'd4);
        hold_req = 1'b1;
        send_random(200);

        // numeric, no idling at all
        set_config(MODE_NUM, 32'd1, 32'd1);
        quiet_mode = 1'b1;
        send_random(100);
        quiet_mode = 1'b0;

        set_config(MODE_NONE, 32'd6, 32'd2);
        send_random(80);
        set_config(MODE_DICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_random(80);
        set_config(MODE_DICT, 32'd1, 32'hFFFF_FFFF);
        send_random(80);
        set_config(MODE_NUM, 32'hFFFF_FFFF, 32'd1);
        send_random(80);
        set_config(MODE_CAT, 32'd0, 32'd0);
        send_random(40);

        // random settings
        for (int p = 0; p < 4; p++) begin
            set_config(t_mode'($urandom_range(3)), pick_rows(), pick_rows());
            send_random(50);
        end

        // drain
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/psm_pkg.sv
design/pooled_stats_merge_unit.sv
tb/pooled_stats_merge_checker.sv
tb/tb_pooled_stats_merge_unit.sv
